// File: hdl/vsmn_pkg.sv
// Shared types and constants for the vector sum / max / L2 norm reduction.
// Used by every module under hdl/. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vsmn_pkg;

    // Field widths
    localparam int ELEM_W   = 16;
    localparam int SUM_W    = 28;
    localparam int SQ_W     = 43;
    localparam int SQP_W    = 31;   // one square, at most 2^30
    localparam int ROOT_W   = 22;   // floor sqrt of a 43-bit value
    localparam int NORM_W   = 24;
    localparam int INV_W    = 25;
    localparam int RAD_W    = 44;   // radicand, even width for two-bit digits
    localparam int SREM_W   = 25;   // square root partial remainder
    localparam int DREM_W   = 23;   // divider partial remainder
    localparam int OUT_W    = 96;   // result tdata, padded to bytes
    localparam int IN_W     = 16;   // element tdata

    // Iteration counts of the back end
    localparam int SQRT_STEPS = RAD_W / 2;
    localparam int DIV_STEPS  = INV_W;
    localparam int STEP_W     = 5;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Saturation limits and reset values
    localparam logic signed [SUM_W-1:0]  SUM_MAX  = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0]  SUM_MIN  = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic        [SQ_W-1:0]   SQ_MAX   = {SQ_W{1'b1}};
    localparam logic signed [ELEM_W-1:0] MAX_INIT = {1'b1, {(ELEM_W-1){1'b0}}};
    localparam logic        [INV_W-1:0]  INV_ONE  = {1'b1, {(INV_W-1){1'b0}}};

    // One finished vector, handed from front to back
    typedef struct packed {
        logic signed [SUM_W-1:0]  total;
        logic signed [ELEM_W-1:0] largest;
        logic        [SQ_W-1:0]   sq;
    } vec_rec_t;

    // Queue fill status seen by the front
    typedef struct packed {
        logic full;
        logic one_left;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SQRT,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

`default_nettype wire

// File: hdl/vector_sum_max_norm_reduce_core.sv
// Top level of the vector sum / max / L2 norm reduction.
// Depends on vsmn_pkg, vsmn_front, vsmn_queue and vsmn_back.
//
// Usage:
//   Slave channel (s_*): one signed Q8.8 element per item in s_tdata, with
//   s_tlast high on the final element of a vector.
//   Master channel (m_*): one item per vector: sum, maximum, L2 norm and
//   inverse norm in m_tdata; m_tuser is high when the norm is zero and the
//   inverse is saturated to 2^24.
//   Throughput: elements are taken one per cycle while s_tready is high.
//   Each vector then passes through the back end as a load, 22 square
//   root steps, 25 divide steps and an output load; a zero norm skips
//   the divide, so short vectors are limited by the back end.
//   A two-entry queue holds finished vectors; s_tready drops only when that
//   queue could overflow. When the receiver stalls, the result holds in the
//   output register, the back end waits with the next result, and the front
//   keeps taking elements until the queue fills.
//   Reset clears all accumulators, the queue and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module vector_sum_max_norm_reduce_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [vsmn_pkg::IN_W-1:0]    s_tdata,   // [15:0] element
    input  wire logic                         s_tlast,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [27:0] total, [43:28] largest, [67:44] norm, [92:68] norm_inverse, rest zero
    output logic [vsmn_pkg::OUT_W-1:0]        m_tdata,
    output logic                              m_tuser    // [0] zero_norm
);

    logic                 push;
    logic                 pop;
    logic                 not_empty;
    vsmn_pkg::vec_rec_t   wr_rec;
    vsmn_pkg::vec_rec_t   rd_rec;
    vsmn_pkg::q_status_t  q_status;

    vsmn_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .element  (s_tdata[vsmn_pkg::ELEM_W-1:0]),
        .last     (s_tlast),
        .q_status (q_status),
        .push     (push),
        .rec      (wr_rec)
    );

    vsmn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_rec    (wr_rec),
        .pop       (pop),
        .not_empty (not_empty),
        .rd_rec    (rd_rec),
        .status    (q_status)
    );

    vsmn_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (not_empty),
        .q_rec    (rd_rec),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

// File: hdl/vsmn_front.sv
// Front end: accepts elements, squares them and keeps the running sum,
// sum of squares and maximum. Depends on vsmn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vsmn_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [vsmn_pkg::ELEM_W-1:0] element,
    input  wire logic                              last,
    input  wire vsmn_pkg::q_status_t               q_status,
    output logic                                   push,
    output vsmn_pkg::vec_rec_t                     rec
);

    logic                                   st_valid_reg, st_valid_next;
    logic                                   st_last_reg;
    logic signed [vsmn_pkg::ELEM_W-1:0]     st_elem_reg;
    logic        [vsmn_pkg::SQP_W-1:0]      st_sq_reg;
    logic signed [vsmn_pkg::SUM_W-1:0]      sum_acc_reg, sum_acc_next;
    logic        [vsmn_pkg::SQ_W-1:0]       sq_acc_reg, sq_acc_next;
    logic signed [vsmn_pkg::ELEM_W-1:0]     max_reg, max_next;

    logic signed [2*vsmn_pkg::ELEM_W-1:0]   prod;
    logic signed [vsmn_pkg::SUM_W:0]        sum_wide;
    logic        [vsmn_pkg::SQ_W:0]         sq_wide;
    logic signed [vsmn_pkg::SUM_W-1:0]      sum_new;
    logic        [vsmn_pkg::SQ_W-1:0]       sq_new;
    logic signed [vsmn_pkg::ELEM_W-1:0]     max_new;
    logic                                   in_fire;

    // Hold off when a pending last element could find the queue full
    assign in_ready = !q_status.full
                      && !(q_status.one_left && st_valid_reg && st_last_reg);
    assign in_fire  = in_valid && in_ready;
    assign st_valid_next = in_fire;

    // Square at the input, registered before accumulation
    assign prod = element * element;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            st_elem_reg <= element;
            st_last_reg <= last;
            st_sq_reg   <= prod[vsmn_pkg::SQP_W-1:0];
        end
    end

    // Saturating accumulation and running maximum
    always_comb
    begin
        sum_wide = {sum_acc_reg[vsmn_pkg::SUM_W-1], sum_acc_reg}
                   + {{(vsmn_pkg::SUM_W-vsmn_pkg::ELEM_W+1){st_elem_reg[vsmn_pkg::ELEM_W-1]}},
                      st_elem_reg};
        if (sum_wide[vsmn_pkg::SUM_W] != sum_wide[vsmn_pkg::SUM_W-1])
        begin
            sum_new = sum_wide[vsmn_pkg::SUM_W] ? vsmn_pkg::SUM_MIN : vsmn_pkg::SUM_MAX;
        end
        else
        begin
            sum_new = sum_wide[vsmn_pkg::SUM_W-1:0];
        end

        sq_wide = {1'b0, sq_acc_reg}
                  + {{(vsmn_pkg::SQ_W-vsmn_pkg::SQP_W+1){1'b0}}, st_sq_reg};
        sq_new  = sq_wide[vsmn_pkg::SQ_W] ? vsmn_pkg::SQ_MAX : sq_wide[vsmn_pkg::SQ_W-1:0];

        max_new = (st_elem_reg > max_reg) ? st_elem_reg : max_reg;
    end

    // Vector end: hand the record over and start from the reset values
    always_comb
    begin
        sum_acc_next = sum_acc_reg;
        sq_acc_next  = sq_acc_reg;
        max_next     = max_reg;
        if (st_valid_reg)
        begin
            if (st_last_reg)
            begin
                sum_acc_next = '0;
                sq_acc_next  = '0;
                max_next     = vsmn_pkg::MAX_INIT;
            end
            else
            begin
                sum_acc_next = sum_new;
                sq_acc_next  = sq_new;
                max_next     = max_new;
            end
        end
    end

    assign push        = st_valid_reg && st_last_reg;
    assign rec.total   = sum_new;
    assign rec.largest = max_new;
    assign rec.sq      = sq_new;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_acc_reg <= '0;
            sq_acc_reg  <= '0;
            max_reg     <= vsmn_pkg::MAX_INIT;
        end
        else
        begin
            sum_acc_reg <= sum_acc_next;
            sq_acc_reg  <= sq_acc_next;
            max_reg     <= max_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/vsmn_queue.sv
// Small register queue of finished vector records between front and back.
// Depends on vsmn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vsmn_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire vsmn_pkg::vec_rec_t wr_rec,
    input  wire logic               pop,
    output logic                    not_empty,
    output vsmn_pkg::vec_rec_t      rd_rec,
    output vsmn_pkg::q_status_t     status
);

    vsmn_pkg::vec_rec_t               entry_reg [vsmn_pkg::QUEUE_DEPTH];
    logic [vsmn_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [vsmn_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [vsmn_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             do_push, do_pop;

    assign do_push = push && !status.full;
    assign do_pop  = pop && not_empty;

    // Pointer and count bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == vsmn_pkg::QPTR_W'(vsmn_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == vsmn_pkg::QPTR_W'(vsmn_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    assign not_empty       = (count_reg != '0);
    assign rd_rec          = entry_reg[rd_ptr_reg];
    assign status.full     = (count_reg == vsmn_pkg::QCNT_W'(vsmn_pkg::QUEUE_DEPTH));
    assign status.one_left = (count_reg == vsmn_pkg::QCNT_W'(vsmn_pkg::QUEUE_DEPTH - 1));

endmodule

`default_nettype wire

// File: hdl/vsmn_back.sv
// Back end: bit-serial square root, then restoring divide for 2^24 / norm,
// then the result output register. Depends on vsmn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module vsmn_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          q_valid,
    input  wire vsmn_pkg::vec_rec_t            q_rec,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [vsmn_pkg::OUT_W-1:0]         m_tdata,
    output logic                               m_tuser
);

    vsmn_pkg::back_state_t                  state_reg, state_next;
    logic [vsmn_pkg::STEP_W-1:0]            step_reg, step_next;
    logic [vsmn_pkg::RAD_W-1:0]             rad_reg, rad_next;
    logic [vsmn_pkg::SREM_W-1:0]            srem_reg, srem_next;
    logic [vsmn_pkg::ROOT_W-1:0]            root_reg, root_next;
    logic [vsmn_pkg::DREM_W-1:0]            drem_reg, drem_next;
    logic [vsmn_pkg::INV_W-1:0]             quo_reg, quo_next;
    logic signed [vsmn_pkg::SUM_W-1:0]      total_reg, total_next;
    logic signed [vsmn_pkg::ELEM_W-1:0]     largest_reg, largest_next;
    logic                                   zero_reg, zero_next;
    logic                                   out_valid_reg, out_valid_next;
    logic [vsmn_pkg::OUT_W-1:0]             out_data_reg, out_data_next;
    logic                                   out_user_reg, out_user_next;

    logic [vsmn_pkg::SREM_W-1:0]            srem_sh, s_trial;
    logic [vsmn_pkg::DREM_W-1:0]            drem_sh, divisor;
    logic                                   s_fit, d_fit;
    logic                                   last_step_sqrt, last_step_div;
    logic                                   out_free;

    // One root bit per cycle
    assign srem_sh = {srem_reg[vsmn_pkg::SREM_W-3:0], rad_reg[vsmn_pkg::RAD_W-1 -: 2]};
    assign s_trial = {1'b0, root_reg, 2'b01};
    assign s_fit   = (srem_sh >= s_trial);

    // One quotient bit per cycle; dividend shifts out of quo_reg
    assign drem_sh = {drem_reg[vsmn_pkg::DREM_W-2:0], quo_reg[vsmn_pkg::INV_W-1]};
    assign divisor = {1'b0, root_reg};
    assign d_fit   = (drem_sh >= divisor);

    assign last_step_sqrt = (step_reg == vsmn_pkg::STEP_W'(vsmn_pkg::SQRT_STEPS - 1));
    assign last_step_div  = (step_reg == vsmn_pkg::STEP_W'(vsmn_pkg::DIV_STEPS - 1));
    assign out_free       = !out_valid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vsmn_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = vsmn_pkg::BK_SQRT;
                end
            end
            vsmn_pkg::BK_SQRT:
            begin
                if (last_step_sqrt)
                begin
                    state_next = (root_next == '0) ? vsmn_pkg::BK_DONE : vsmn_pkg::BK_DIV;
                end
            end
            vsmn_pkg::BK_DIV:
            begin
                if (last_step_div)
                begin
                    state_next = vsmn_pkg::BK_DONE;
                end
            end
            vsmn_pkg::BK_DONE:
            begin
                if (out_free)
                begin
                    state_next = vsmn_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = vsmn_pkg::BK_IDLE;
            end
        endcase
    end

    // Datapath and outputs per state
    always_comb
    begin
        q_pop          = 1'b0;
        step_next      = step_reg;
        rad_next       = rad_reg;
        srem_next      = srem_reg;
        root_next      = root_reg;
        drem_next      = drem_reg;
        quo_next       = quo_reg;
        total_next     = total_reg;
        largest_next   = largest_reg;
        zero_next      = zero_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        case (state_reg)
            vsmn_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    total_next   = q_rec.total;
                    largest_next = q_rec.largest;
                    rad_next     = {1'b0, q_rec.sq};
                    srem_next    = '0;
                    root_next    = '0;
                    step_next    = '0;
                end
            end
            vsmn_pkg::BK_SQRT:
            begin
                rad_next  = {rad_reg[vsmn_pkg::RAD_W-3:0], 2'b00};
                srem_next = s_fit ? srem_sh - s_trial : srem_sh;
                root_next = {root_reg[vsmn_pkg::ROOT_W-2:0], s_fit};
                step_next = step_reg + 1'b1;
                if (last_step_sqrt)
                begin
                    step_next = '0;
                    drem_next = '0;
                    quo_next  = vsmn_pkg::INV_ONE;
                    zero_next = (root_next == '0);
                end
            end
            vsmn_pkg::BK_DIV:
            begin
                drem_next = d_fit ? drem_sh - divisor : drem_sh;
                quo_next  = {quo_reg[vsmn_pkg::INV_W-2:0], d_fit};
                step_next = step_reg + 1'b1;
            end
            vsmn_pkg::BK_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{(vsmn_pkg::OUT_W - vsmn_pkg::SUM_W - vsmn_pkg::ELEM_W
                                        - vsmn_pkg::NORM_W - vsmn_pkg::INV_W){1'b0}},
                                      quo_reg,
                                      {(vsmn_pkg::NORM_W - vsmn_pkg::ROOT_W){1'b0}},
                                      root_reg,
                                      largest_reg,
                                      total_reg};
                    out_user_next  = zero_reg;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vsmn_pkg::BK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg      <= rad_next;
        srem_reg     <= srem_next;
        root_reg     <= root_next;
        drem_reg     <= drem_next;
        quo_reg      <= quo_next;
        total_reg    <= total_next;
        largest_reg  <= largest_next;
        zero_reg     <= zero_next;
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

// File: test/tb_vector_sum_max_norm_reduce_core.sv
// Testbench for vector_sum_max_norm_reduce_core: streams signed Q8.8 vectors and checks
// each sum / max / L2 norm / inverse norm item against an in-bench predictor.
// Depends on vsmn_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module tb_vector_sum_max_norm_reduce_core;
    import vsmn_pkg::*;

    // Clamp limits of the accumulators and the inverse numerator
    localparam longint          SUM_HI   = 134217727;
    localparam longint          SUM_LO   = -134217728;
    localparam longint unsigned SQ_TOP   = (64'd1 << 43) - 64'd1;
    localparam longint unsigned INV_FULL = 64'd1 << 24;
    localparam int              QUIET_LIMIT = 4000;
    localparam int              HOLD_CYCLES = 300;
    localparam int              RANDOM_ITEMS = 670;

    typedef enum int {
        ELEM_ANY,
        ELEM_SMALL,
        ELEM_EXTREME,
        ELEM_NEG,
        ELEM_ZERO
    } elem_mix_t;

    typedef struct {
        logic signed [SUM_W-1:0]  total;
        logic signed [ELEM_W-1:0] largest;
        logic        [NORM_W-1:0] norm;
        logic        [INV_W-1:0]  norm_inverse;
        logic                     zero_norm;
    } reduction_t;

    // Running reductions of the current vector and the items still owed
    class norm_scoreboard;
        longint          run_sum;
        longint unsigned run_sq;
        int              run_peak;
        reduction_t      due_q[$];
        int              errors;

        function new();
            errors = 0;
            clear_vector();
        endfunction

        function void clear_vector();
            run_sum  = 0;
            run_sq   = 0;
            run_peak = -32768;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        // Fold one accepted element in; on the last one queue the reductions
        function void note_element(logic [ELEM_W-1:0] value, logic is_last);
            int              ev;
            longint          s;
            longint unsigned sq;
            longint unsigned rest;
            longint unsigned root;
            longint unsigned step_bit;
            reduction_t      r;
            ev = $signed(value);
            s = run_sum + ev;
            if (s > SUM_HI)
                s = SUM_HI;
            if (s < SUM_LO)
                s = SUM_LO;
            run_sum = s;
            sq = longint'(ev) * longint'(ev);
            if (run_sq > SQ_TOP - sq)
                run_sq = SQ_TOP;
            else
                run_sq = run_sq + sq;
            if (ev > run_peak)
                run_peak = ev;
            if (!is_last)
                return;
            // floor square root, two bits per step
            rest = run_sq;
            root = 0;
            step_bit = 64'd1 << 44;
            while (step_bit > rest)
                step_bit = step_bit >> 2;
            while (step_bit != 0)
            begin
                if (rest >= root + step_bit)
                begin
                    rest = rest - (root + step_bit);
                    root = (root >> 1) + step_bit;
                end
                else
                    root = root >> 1;
                step_bit = step_bit >> 2;
            end
            r.total        = run_sum[SUM_W-1:0];
            r.largest      = run_peak[ELEM_W-1:0];
            r.norm         = root[NORM_W-1:0];
            r.norm_inverse = (root == 0) ? INV_FULL[INV_W-1:0] : INV_W'(INV_FULL / root);
            r.zero_norm    = (root == 0);
            due_q.push_back(r);
            clear_vector();
        endfunction

        // Compare one result item with the oldest owed reduction
        function void check_result(logic [OUT_W-1:0] data, logic flag);
            reduction_t want;
            reduction_t got;
            if (due_q.size() == 0)
            begin
                $error("unexpected result item, data %h flag %b", data, flag);
                errors++;
                return;
            end
            want = due_q.pop_front();
            got.total        = data[27:0];
            got.largest      = data[43:28];
            got.norm         = data[67:44];
            got.norm_inverse = data[92:68];
            got.zero_norm    = flag;
            if (got.total !== want.total)
            begin
                $error("total: expected %0d, got %0d", want.total, got.total);
                errors++;
            end
            if (got.largest !== want.largest)
            begin
                $error("largest: expected %0d, got %0d", want.largest, got.largest);
                errors++;
            end
            if (got.norm !== want.norm)
            begin
                $error("norm: expected %0d, got %0d", want.norm, got.norm);
                errors++;
            end
            if (got.norm_inverse !== want.norm_inverse)
            begin
                $error("norm_inverse: expected %0d, got %0d",
                       want.norm_inverse, got.norm_inverse);
                errors++;
            end
            if (got.zero_norm !== want.zero_norm)
            begin
                $error("zero_norm: expected %0d, got %0d", want.zero_norm, got.zero_norm);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              s_tlast;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tuser;

    norm_scoreboard sb = new();
    bit  idle_on  = 1'b1;
    bit  hold_req = 1'b0;
    int  random_sent = 0;

    vector_sum_max_norm_reduce_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    initial
        clk = 1'b0;
    always #4 clk = ~clk;

    // Element value drawn from one of several mixes
    function automatic logic [ELEM_W-1:0] pick_elem(elem_mix_t mix);
        logic [ELEM_W-1:0] v;
        case (mix)
            ELEM_ANY:   v = ELEM_W'($urandom_range(0, 65535));
            ELEM_SMALL: v = ELEM_W'($urandom_range(0, 1023) - 512);
            ELEM_EXTREME:
            begin
                case ($urandom_range(0, 5))
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    2:       v = 16'h0000;
                    3:       v = 16'hFFFF;
                    4:       v = 16'h0001;
                    default: v = 16'h8001;
                endcase
            end
            ELEM_NEG:   v = 16'h8000 | ELEM_W'($urandom_range(0, 32767));
            default:    v = '0;
        endcase
        return v;
    endfunction

    // Offer one element, with an optional gap, and wait until it is taken
    task automatic send_elem(input logic [ELEM_W-1:0] value, input logic is_last);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_element(value, is_last);
    endtask

    // A vector of random elements from one mix
    task automatic send_vector(input int len, input elem_mix_t mix);
        for (int i = 0; i < len; i++)
            send_elem(pick_elem(mix), i == len - 1);
    endtask

    // A run of one repeated value
    task automatic send_fill(input logic [ELEM_W-1:0] value, input int count,
                             input logic ends_vector);
        for (int i = 0; i < count; i++)
            send_elem(value, ends_vector && (i == count - 1));
    endtask

    // Receiver: random stall bursts, one long hold on request
    initial
    begin
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                m_tready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Result monitor
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
        end
    end

    // Watchdog on cycles with no item moving on either side
    initial
    begin
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // Stimulus
    initial
    begin
        int        len;
        int        pick;
        elem_mix_t mix;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tlast  <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero norm, smallest nonzero norm, field extremes
        send_elem(16'h0000, 1'b1);
        send_elem(16'h0001, 1'b1);
        send_elem(16'h8000, 1'b1);
        send_elem(16'h7FFF, 1'b1);
        send_fill(16'h0000, 3, 1'b1);
        send_elem(16'hFFFF, 1'b0);
        send_elem(16'hFFFE, 1'b0);
        send_elem(16'hFFFD, 1'b1);
        send_elem(16'h7FFF, 1'b0);
        send_elem(16'h8000, 1'b0);
        send_elem(16'h0001, 1'b0);
        send_elem(16'hFFFF, 1'b0);
        send_elem(16'h0000, 1'b1);
        send_elem(16'h0100, 1'b0);
        send_elem(16'hFF00, 1'b1);

        // Receiver holds off while short vectors keep coming
        hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send_vector($urandom_range(1, 3), ELEM_ANY);
        idle_on = 1'b1;

        // Random vectors; idling stops in the last part
        while (random_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                len = $urandom_range(1, 8);
            else if (pick < 95)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(41, 120);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                mix = ELEM_ANY;
            else if (pick < 65)
                mix = ELEM_SMALL;
            else if (pick < 80)
                mix = ELEM_EXTREME;
            else if (pick < 95)
                mix = ELEM_NEG;
            else
                mix = ELEM_ZERO;
            if (random_sent > RANDOM_ITEMS - 130)
                idle_on = 1'b0;
            else if ($urandom_range(0, 9) == 0)
                idle_on = !idle_on;
            send_vector(len, mix);
            random_sent += len;
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // Drain, then allow for stray items from the back end
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
